// ----- hdl/debounced_step_counter_display_assert.svh -----
// Assertion macros shared by the step counter display RTL.
// Each macro expects signals named clk and rst_n in the including module.
`ifndef DEBOUNCED_STEP_COUNTER_DISPLAY_ASSERT_SVH
`define DEBOUNCED_STEP_COUNTER_DISPLAY_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define DSCD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define DSCD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/dscd_pkg.sv -----
// Package for the debounced step counter display: sizes, glyph codes,
// register map, state types and inter-module structs. No dependencies.
`timescale 1ns / 1ps

package dscd_pkg;

    // Display and value sizes.
    localparam int DIGIT_SLOTS = 5;
    localparam int VALUE_BITS  = 16;
    localparam int CFG_W       = 16;
    localparam int ADDR_W      = 4;
    localparam int DATA_W      = 32;
    localparam int GLYPH_W     = 4;
    localparam int POS_W       = 3;
    localparam int CNT_W       = $clog2(DIGIT_SLOTS + 1);
    localparam int BCD_W       = 4 * DIGIT_SLOTS;
    localparam int BITCNT_W    = $clog2(VALUE_BITS);

    // Glyph codes beyond the decimal digits.
    localparam logic [GLYPH_W-1:0] GLYPH_PLUS  = 4'd10;
    localparam logic [GLYPH_W-1:0] GLYPH_MINUS = 4'd11;
    localparam logic [GLYPH_W-1:0] GLYPH_BLANK = 4'd12;

    // Register indexes (word address).
    localparam logic [1:0] REG_STEP    = 2'd0;
    localparam logic [1:0] REG_LOCKOUT = 2'd1;
    localparam logic [1:0] REG_START   = 2'd2;

    // Register reset values.
    localparam logic [CFG_W-1:0] STEP_RESET    = 16'hFDB1;
    localparam logic [CFG_W-1:0] LOCKOUT_RESET = 16'h0500;
    localparam logic [CFG_W-1:0] START_RESET   = 16'd3184;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_CONV,
        ST_SHOW
    } top_state_t;

    typedef enum logic [1:0] {
        B2D_IDLE,
        B2D_SHIFT,
        B2D_TRIM
    } b2d_state_t;

    typedef enum logic {
        GLY_IDLE,
        GLY_RUN
    } gly_state_t;

    // Conversion request and result.
    typedef struct packed {
        logic                  start;
        logic [VALUE_BITS-1:0] mag;
    } b2d_req_t;

    typedef struct packed {
        logic             done;
        logic [BCD_W-1:0] bcd;
        logic [CNT_W-1:0] count;
    } b2d_res_t;

    // Glyph run request.
    typedef struct packed {
        logic             start;
        logic             negative;
        logic [BCD_W-1:0] bcd;
        logic [CNT_W-1:0] count;
    } gly_req_t;

endpackage

// ----- hdl/dscd_if.sv -----
// Handshake channel interfaces for the tick input and the glyph output.
// Depends on dscd_pkg for the glyph and position widths.
`timescale 1ns / 1ps

interface dscd_in_if;
    logic valid;
    logic ready;
    logic button_level;

    modport source (output valid, output button_level, input ready);
    modport sink (input valid, input button_level, output ready);
endinterface

interface dscd_out_if import dscd_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [GLYPH_W-1:0] glyph;
    logic [POS_W-1:0]   position;
    logic               last;

    modport source (output valid, output glyph, output position, output last, input ready);
    modport sink (input valid, input glyph, input position, input last, output ready);
endinterface

// ----- hdl/debounced_step_counter_display.sv -----
// A tick that is not an accepted press leaves the sequencer idle and ready
// for the next tick. An accepted press passes through the load state, the
// bit-serial BCD converter and the leading zero trim before its first glyph
// is shown; the six glyphs then follow one per cycle while the output is not
// stalled, and the next tick is taken only once the glyph run is done.
// Reset is asynchronous: registers to their defaults, value to the start value.
`timescale 1ns / 1ps
`include "debounced_step_counter_display_assert.svh"

module debounced_step_counter_display import dscd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    dscd_in_if.sink           in_ch,
    dscd_out_if.source        out_ch
);

    top_state_t            state_reg, state_next;
    logic [CFG_W-1:0]      step_reg, step_next;
    logic [CFG_W-1:0]      lock_ticks_reg, lock_ticks_next;
    logic [CFG_W-1:0]      start_reg, start_next;
    logic [VALUE_BITS-1:0] value_reg, value_next;
    logic                  prev_level_reg, prev_level_next;
    logic                  await_press_reg, await_press_next;
    logic [CFG_W-1:0]      lock_rem_reg, lock_rem_next;

    logic       in_xfer;
    logic       cfg_write;
    logic [1:0] reg_index;
    logic       locked;
    logic       awaited;
    logic       take_edge;
    logic       press;
    b2d_req_t   b2d_req;
    b2d_res_t   b2d_res;
    gly_req_t   gly_req;
    logic       gly_done;

    assign in_xfer   = in_ch.valid && in_ch.ready;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_index = paddr[3:2];

    // Edge detection against the awaited direction and the lockout.
    always_comb
    begin
        locked    = (lock_rem_reg != '0);
        awaited   = await_press_reg ? (prev_level_reg && !in_ch.button_level)
                                    : (!prev_level_reg && in_ch.button_level);
        take_edge = awaited && !locked;
        press     = take_edge && await_press_reg;
    end

    // Tick state and register writes.
    always_comb
    begin
        step_next        = step_reg;
        lock_ticks_next  = lock_ticks_reg;
        start_next       = start_reg;
        value_next       = value_reg;
        prev_level_next  = prev_level_reg;
        await_press_next = await_press_reg;
        lock_rem_next    = lock_rem_reg;
        if (in_xfer)
        begin
            prev_level_next  = in_ch.button_level;
            await_press_next = await_press_reg ^ take_edge;
            if (press)
            begin
                value_next    = value_reg + VALUE_BITS'($signed(step_reg));
                lock_rem_next = lock_ticks_reg;
            end
            else if (locked)
            begin
                lock_rem_next = lock_rem_reg - CFG_W'(1);
            end
        end
        if (cfg_write)
        begin
            unique case (reg_index)
                REG_STEP:    step_next = pwdata[CFG_W-1:0];
                REG_LOCKOUT: lock_ticks_next = pwdata[CFG_W-1:0];
                REG_START:
                begin
                    start_next = pwdata[CFG_W-1:0];
                    value_next = VALUE_BITS'($signed(pwdata[CFG_W-1:0]));
                end
                default:     step_next = step_reg;
            endcase
        end
    end

    // Register read back.
    always_comb
    begin
        pready = 1'b1;
        unique case (reg_index)
            REG_STEP:    prdata = DATA_W'(step_reg);
            REG_LOCKOUT: prdata = DATA_W'(lock_ticks_reg);
            REG_START:   prdata = DATA_W'(start_reg);
            default:     prdata = '0;
        endcase
    end

    // Sequencer next state.
    always_comb
    begin
        unique case (state_reg)
            ST_IDLE: state_next = (in_xfer && press) ? ST_LOAD : ST_IDLE;
            ST_LOAD: state_next = ST_CONV;
            ST_CONV: state_next = b2d_res.done ? ST_SHOW : ST_CONV;
            ST_SHOW: state_next = gly_done ? ST_IDLE : ST_SHOW;
            default: state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs; the magnitude is formed unsigned.
    always_comb
    begin
        in_ch.ready      = (state_reg == ST_IDLE);
        b2d_req.start    = (state_reg == ST_LOAD);
        b2d_req.mag      = value_reg[VALUE_BITS-1] ? (~value_reg + VALUE_BITS'(1)) : value_reg;
        gly_req.start    = b2d_res.done;
        gly_req.negative = value_reg[VALUE_BITS-1];
        gly_req.bcd      = b2d_res.bcd;
        gly_req.count    = b2d_res.count;
    end

    dscd_b2d u_b2d (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (b2d_req),
        .res   (b2d_res)
    );

    dscd_glyph u_glyph (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (gly_req),
        .done   (gly_done),
        .out_ch (out_ch)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            step_reg        <= STEP_RESET;
            lock_ticks_reg  <= LOCKOUT_RESET;
            start_reg       <= START_RESET;
            value_reg       <= VALUE_BITS'($signed(START_RESET));
            prev_level_reg  <= 1'b1;
            await_press_reg <= 1'b1;
            lock_rem_reg    <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            step_reg        <= step_next;
            lock_ticks_reg  <= lock_ticks_next;
            start_reg       <= start_next;
            value_reg       <= value_next;
            prev_level_reg  <= prev_level_next;
            await_press_reg <= await_press_next;
            lock_rem_reg    <= lock_rem_next;
        end
    end

    // A press transfer always launches a conversion.
    `DSCD_ASSERT_NEXT(a_press_loads, in_xfer && press, state_reg == ST_LOAD, "press did not start conversion")
    // The converter finishes only while the sequencer waits for it.
    `DSCD_ASSERT_NOW(a_conv_done_phase, b2d_res.done, state_reg == ST_CONV, "conversion done out of phase")
    // The glyph run ends only while the sequencer is showing.
    `DSCD_ASSERT_NOW(a_show_done_phase, gly_done, state_reg == ST_SHOW, "glyph run done out of phase")

endmodule

// ----- hdl/dscd_b2d.sv -----
// Bit-serial binary to BCD converter (shift and add three), one magnitude
// bit per cycle, followed by a digit-serial leading zero trim. Uses dscd_pkg.
`timescale 1ns / 1ps

module dscd_b2d import dscd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  b2d_req_t req,
    output b2d_res_t res
);

    b2d_state_t            state_reg, state_next;
    logic [VALUE_BITS-1:0] mag_reg, mag_next;
    logic [BCD_W-1:0]      bcd_reg, bcd_next;
    logic                  ovf_reg, ovf_next;
    logic [BITCNT_W-1:0]   bit_cnt_reg, bit_cnt_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [BCD_W-1:0]      adjusted;
    logic                  last_bit;
    logic                  trim_more;

    // Add three to every digit of five or more before the shift.
    always_comb
    begin
        for (int i = 0; i < DIGIT_SLOTS; i++)
        begin
            if (bcd_reg[4*i +: 4] >= 4'd5)
                adjusted[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            else
                adjusted[4*i +: 4] = bcd_reg[4*i +: 4];
        end
    end

    assign last_bit  = (bit_cnt_reg == BITCNT_W'(VALUE_BITS - 1));
    // A zero top digit is dropped unless the value overflowed the slots
    // or it is the only digit left.
    assign trim_more = (bcd_reg[BCD_W-1 -: 4] == 4'd0) && !ovf_reg
                       && (count_reg > CNT_W'(1));

    // Next state.
    always_comb
    begin
        unique case (state_reg)
            B2D_IDLE:  state_next = req.start ? B2D_SHIFT : B2D_IDLE;
            B2D_SHIFT: state_next = last_bit ? B2D_TRIM : B2D_SHIFT;
            B2D_TRIM:  state_next = trim_more ? B2D_TRIM : B2D_IDLE;
            default:   state_next = B2D_IDLE;
        endcase
    end

    // Datapath updates.
    always_comb
    begin
        mag_next     = mag_reg;
        bcd_next     = bcd_reg;
        ovf_next     = ovf_reg;
        bit_cnt_next = bit_cnt_reg;
        count_next   = count_reg;
        unique case (state_reg)
            B2D_IDLE:
            begin
                if (req.start)
                begin
                    mag_next     = req.mag;
                    bcd_next     = '0;
                    ovf_next     = 1'b0;
                    bit_cnt_next = '0;
                    count_next   = CNT_W'(DIGIT_SLOTS);
                end
            end
            B2D_SHIFT:
            begin
                bcd_next     = {adjusted[BCD_W-2:0], mag_reg[VALUE_BITS-1]};
                ovf_next     = ovf_reg | adjusted[BCD_W-1];
                mag_next     = {mag_reg[VALUE_BITS-2:0], 1'b0};
                bit_cnt_next = bit_cnt_reg + BITCNT_W'(1);
            end
            B2D_TRIM:
            begin
                if (trim_more)
                begin
                    bcd_next   = {bcd_reg[BCD_W-5:0], 4'd0};
                    count_next = count_reg - CNT_W'(1);
                end
            end
            default:
            begin
                bcd_next = bcd_reg;
            end
        endcase
    end

    // Outputs.
    always_comb
    begin
        res.done  = (state_reg == B2D_TRIM) && !trim_more;
        res.bcd   = bcd_reg;
        res.count = count_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= B2D_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        mag_reg     <= mag_next;
        bcd_reg     <= bcd_next;
        ovf_reg     <= ovf_next;
        bit_cnt_reg <= bit_cnt_next;
        count_reg   <= count_next;
    end

endmodule

// ----- hdl/dscd_glyph.sv -----
// Glyph sequencer: sends the sign and then one digit or blank per transfer
// from a digit shift register through an output register. Uses dscd_pkg, dscd_if.
`timescale 1ns / 1ps

module dscd_glyph import dscd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  gly_req_t  req,
    output logic      done,
    dscd_out_if.source out_ch
);

    gly_state_t         state_reg, state_next;
    logic               neg_reg, neg_next;
    logic [BCD_W-1:0]   bcd_reg, bcd_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   pos_reg, pos_next;
    logic               out_valid_reg, out_valid_next;
    logic [GLYPH_W-1:0] glyph_reg, glyph_next;
    logic [POS_W-1:0]   position_reg, position_next;
    logic               last_reg, last_next;
    logic               load;
    logic               final_slot;

    // The output register takes a new glyph when it is empty or draining.
    assign load       = (state_reg == GLY_RUN) && (!out_valid_reg || out_ch.ready);
    assign final_slot = (pos_reg == CNT_W'(DIGIT_SLOTS));

    // Next state.
    always_comb
    begin
        unique case (state_reg)
            GLY_IDLE: state_next = req.start ? GLY_RUN : GLY_IDLE;
            GLY_RUN:  state_next = (load && final_slot) ? GLY_IDLE : GLY_RUN;
            default:  state_next = GLY_IDLE;
        endcase
    end

    // Digit shifting and output register loading.
    always_comb
    begin
        neg_next       = neg_reg;
        bcd_next       = bcd_reg;
        count_next     = count_reg;
        pos_next       = pos_reg;
        glyph_next     = glyph_reg;
        position_next  = position_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;
        if (state_reg == GLY_IDLE && req.start)
        begin
            neg_next   = req.negative;
            bcd_next   = req.bcd;
            count_next = req.count;
            pos_next   = '0;
        end
        if (load)
        begin
            out_valid_next = 1'b1;
            position_next  = POS_W'(pos_reg);
            last_next      = final_slot;
            pos_next       = pos_reg + CNT_W'(1);
            if (pos_reg == '0)
            begin
                glyph_next = neg_reg ? GLYPH_MINUS : GLYPH_PLUS;
            end
            else
            begin
                glyph_next = (pos_reg <= count_reg) ? bcd_reg[BCD_W-1 -: 4] : GLYPH_BLANK;
                bcd_next   = {bcd_reg[BCD_W-5:0], 4'd0};
            end
        end
    end

    // Outputs.
    always_comb
    begin
        done            = load && final_slot;
        out_ch.valid    = out_valid_reg;
        out_ch.glyph    = glyph_reg;
        out_ch.position = position_reg;
        out_ch.last     = last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= GLY_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg      <= neg_next;
        bcd_reg      <= bcd_next;
        count_reg    <= count_next;
        pos_reg      <= pos_next;
        glyph_reg    <= glyph_next;
        position_reg <= position_next;
        last_reg     <= last_next;
    end

endmodule

// ----- verif/glyph_run_checker.sv -----
// Checker for the debounced step counter display: follows register writes and
// button ticks, predicts each glyph run and compares it with the output channel.
// Depends on dscd_pkg and the channel interfaces of dscd_if.sv.
`timescale 1ns / 1ps

module glyph_run_checker import dscd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic              pready,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    dscd_in_if                in_ch,
    dscd_out_if               out_ch,
    output int                fail_count,
    output int                glyphs_due
);

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [GLYPH_W-1:0] glyph;
        logic [POS_W-1:0]   position;
        logic               last;
    } glyph_slot_t;

    // Glyphs predicted but not yet seen on the output channel.
    glyph_slot_t glyphs_expected[$];

    // Shadow copies of the step and lockout registers.
    logic [CFG_W-1:0] step_reg;
    logic [CFG_W-1:0] lockout_reg;

    // Predicted counter state.
    logic [VALUE_BITS-1:0] count_value;
    logic                  last_level;
    logic                  want_press;
    logic [CFG_W-1:0]      lock_count;

    function automatic void note_fail(input string what);
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
            $display("%0t ns glyph check: %s", $realtime, what);
    endfunction

    // Sign glyph, then the decimal digits left-justified, then blanks.
    task automatic push_glyph_run(input logic [VALUE_BITS-1:0] value);
        logic [VALUE_BITS-1:0] mag;
        logic [GLYPH_W-1:0]    digit [DIGIT_SLOTS];
        int                    ndig;
        glyph_slot_t           slot;
        // The magnitude is unsigned, so the most negative value needs no fixup.
        mag = value[VALUE_BITS-1] ? -value : value;
        slot.glyph    = value[VALUE_BITS-1] ? GLYPH_MINUS : GLYPH_PLUS;
        slot.position = '0;
        slot.last     = 1'b0;
        glyphs_expected.push_back(slot);
        ndig = 0;
        do
        begin
            digit[ndig] = GLYPH_W'(mag % 10);
            mag         = VALUE_BITS'(mag / 10);
            ndig++;
        end
        while (mag != 0 && ndig < DIGIT_SLOTS);
        for (int k = 0; k < DIGIT_SLOTS; k++)
        begin
            slot.glyph    = (k < ndig) ? digit[ndig - 1 - k] : GLYPH_BLANK;
            slot.position = POS_W'(k + 1);
            slot.last     = (k == DIGIT_SLOTS - 1);
            glyphs_expected.push_back(slot);
        end
    endtask

    // One timer tick: lockout countdown, edge detection and press handling.
    task automatic predict_tick(input logic level);
        logic locked;
        logic awaited;
        locked  = (lock_count != '0);
        awaited = want_press ? (last_level && !level) : (!last_level && level);
        if (locked)
            lock_count = lock_count - CFG_W'(1);
        if (awaited && !locked)
        begin
            if (want_press)
            begin
                count_value = count_value + VALUE_BITS'(signed'(step_reg));
                lock_count  = lockout_reg;
                push_glyph_run(count_value);
            end
            want_press = !want_press;
        end
        last_level = level;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        glyph_slot_t got;
        glyph_slot_t want;
        if (!rst_n)
        begin
            step_reg    = STEP_RESET;
            lockout_reg = LOCKOUT_RESET;
            count_value = VALUE_BITS'(signed'(START_RESET));
            last_level  = 1'b1;
            want_press  = 1'b1;
            lock_count  = '0;
            glyphs_expected.delete();
            fail_count  = 0;
            glyphs_due  = 0;
        end
        else
        begin
            // Register write; a write to the start value reloads the counter.
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[ADDR_W-1:2])
                    REG_STEP:    step_reg    = pwdata[CFG_W-1:0];
                    REG_LOCKOUT: lockout_reg = pwdata[CFG_W-1:0];
                    REG_START:   count_value = VALUE_BITS'(signed'(pwdata[CFG_W-1:0]));
                    default:     ;
                endcase
            end

            // Glyph transfer against the oldest prediction.
            if (out_ch.valid && out_ch.ready)
            begin
                got = {out_ch.glyph, out_ch.position, out_ch.last};
                if (glyphs_expected.size() == 0)
                    note_fail($sformatf("unexpected glyph %0d at position %0d, last %0b",
                                        got.glyph, got.position, got.last));
                else
                begin
                    want = glyphs_expected.pop_front();
                    if (got !== want)
                        note_fail($sformatf(
                            "expected glyph %0d pos %0d last %0b, got glyph %0d pos %0d last %0b",
                            want.glyph, want.position, want.last,
                            got.glyph, got.position, got.last));
                end
            end

            // Tick transfer.
            if (in_ch.valid && in_ch.ready)
                predict_tick(in_ch.button_level);

            glyphs_due = glyphs_expected.size();
        end
    end

endmodule

// ----- verif/tb_top.sv -----
// Top of the step counter display testbench: clock, reset, register writes,
// button tick stimulus, output stalls, watchdog and the final verdict.
// Depends on dscd_pkg, dscd_if.sv, the block and glyph_run_checker.
`timescale 1ns / 1ps

module tb_top;
    import dscd_pkg::*;

    localparam int         MAX_WAIT      = 18;
    localparam int         SETTLE_CYCLES = 32;
    localparam int         STALL_LIMIT   = 2000;
    localparam int         TICK_TARGET   = 450;
    localparam int         PHASE_MARGIN  = 50;
    localparam int         FIRST_LOCKOUT = 40;
    localparam int         RESET_HOLD    = FIRST_LOCKOUT - 1;
    localparam logic [1:0] REG_SPARE     = 2'd3;

    logic              clk   = 1'b0;
    logic              rst_n = 1'b0;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic              pready;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;

    int          fail_count;
    int          glyphs_due;
    bit          tx_quiet;
    bit          rx_quiet;
    int unsigned rx_hold      = 0;
    int          stall_cycles = 0;
    int          ticks_sent   = 0;
    int          lock_now     = int'(LOCKOUT_RESET);
    logic        level_now    = 1'b1;

    dscd_in_if  in_ch();
    dscd_out_if out_ch();

    debounced_step_counter_display dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .in_ch   (in_ch),
        .out_ch  (out_ch)
    );

    glyph_run_checker glyph_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .pready     (pready),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .in_ch      (in_ch),
        .out_ch     (out_ch),
        .fail_count (fail_count),
        .glyphs_due (glyphs_due)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Output side: after each glyph transfer, stall for a random number of
    // cycles in which a glyph is offered.
    always @(posedge clk)
    begin
        if (out_ch.valid && out_ch.ready)
            rx_hold = rx_quiet ? 0 : $urandom_range(0, MAX_WAIT);
        else if (out_ch.valid && rx_hold != 0)
            rx_hold = rx_hold - 1;
        out_ch.ready <= (rx_hold == 0);
    end

    // Watchdog on cycles without any transfer or register access.
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    task automatic send_tick(input logic level);
        int unsigned gap;
        gap = tx_quiet ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap != 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.button_level <= level;
        do @(posedge clk); while (!in_ch.ready);
        level_now  = level;
        ticks_sent = ticks_sent + 1;
    endtask

    task automatic send_pattern(input string levels);
        for (int i = 0; i < levels.len(); i++)
            send_tick(levels[i] == "1");
    endtask

    // Hold off the ticks until every predicted glyph has been transferred.
    task automatic wait_results();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (glyphs_due != 0)
            @(posedge clk);
    endtask

    // Setup and access cycle; the upper data bits carry noise.
    task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= ($urandom() << CFG_W) | DATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic configure(input logic [CFG_W-1:0] step, input logic [CFG_W-1:0] lockout,
                             input logic [CFG_W-1:0] start, input bit load_start);
        wait_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        write_reg(REG_STEP, step);
        write_reg(REG_LOCKOUT, lockout);
        if (load_start)
            write_reg(REG_START, start);
        lock_now = int'(lockout);
    endtask

    function automatic logic [CFG_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'($urandom_range(0, 40)) - 16'd20;
            default: return 16'($urandom());
        endcase
    endfunction

    // Short lockouts keep presses frequent; a lockout outlives its phase.
    function automatic logic [CFG_W-1:0] pick_lockout();
        case ($urandom_range(0, 9))
            0:       return 16'd0;
            1:       return 16'd1;
            2:       return 16'($urandom_range(8, 60));
            default: return 16'($urandom_range(0, 6));
        endcase
    endfunction

    initial
    begin
        int phase_end;
        int run_len;
        psel               <= 1'b0;
        penable            <= 1'b0;
        pwrite             <= 1'b0;
        paddr              <= '0;
        pwdata             <= '0;
        in_ch.valid        <= 1'b0;
        in_ch.button_level <= 1'b1;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset step and start value with a shorter lockout: one press, then
        // the release falls inside the lockout and must be dropped.
        configure(STEP_RESET, 16'(FIRST_LOCKOUT), START_RESET, 1'b0);
        send_pattern("0");
        tx_quiet = 1'b1;
        repeat (RESET_HOLD - 1) send_tick(1'b0);
        tx_quiet = 1'b0;
        send_pattern("101");

        // Zero step, zero lockout, zero value: plus sign and a single digit.
        configure(16'd0, 16'd0, 16'd0, 1'b1);
        send_pattern("010");

        // Largest value plus one wraps to the most negative value.
        configure(16'd1, 16'd1, 16'h7FFF, 1'b1);
        send_pattern("101101");

        // Most negative step from zero; a spare register write is ignored.
        configure(16'h8000, 16'd3, 16'd0, 1'b1);
        write_reg(REG_SPARE, 16'hFFFF);
        send_pattern("0101");

        // Largest step onto the most negative start value.
        configure(16'h7FFF, 16'd2, 16'h8000, 1'b1);
        send_pattern("01011");

        // Random phases: mostly clean press and release runs, some bounce.
        while (ticks_sent < TICK_TARGET - PHASE_MARGIN)
        begin
            configure(pick_value(), pick_lockout(), pick_value(), $urandom_range(0, 3) != 0);
            phase_end = ticks_sent + $urandom_range(30, 70);
            while (ticks_sent < phase_end)
            begin
                tx_quiet = ($urandom_range(0, 5) == 0);
                rx_quiet = ($urandom_range(0, 5) == 0);
                if ($urandom_range(0, 29) == 0)
                    wait_results();
                if ($urandom_range(0, 4) == 0)
                    repeat ($urandom_range(2, 8)) send_tick(1'($urandom_range(0, 1)));
                else
                begin
                    run_len = $urandom_range(1, (lock_now < 8 ? lock_now : 8) + 3);
                    repeat (run_len) send_tick(!level_now);
                    repeat (run_len - 1) send_tick(level_now);
                end
            end
        end

        // Closing phase with the longest lockout.
        configure(pick_value(), 16'hFFFF, pick_value(), 1'b1);
        repeat (6) send_tick(!level_now);

        wait_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0 && glyphs_due == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
